>>> sv/mdu_pkg.sv
// Package with the request codes, register map, status bits and state encoding of the divide unit.
`default_nettype none

package mdu_pkg;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NOP   = 2'd3
    } req_t;

    localparam logic [2:0] REG_MD0    = 3'd0;
    localparam logic [2:0] REG_MD4    = 3'd4;
    localparam logic [2:0] REG_MD5    = 3'd5;
    localparam logic [2:0] REG_STATUS = 3'd6;

    localparam int NUM_DATA_REGS = 6;

    localparam logic [7:0] ST_ERROR    = 8'h80;
    localparam logic [7:0] ST_OVERFLOW = 8'h40;

    localparam int DIV_BITS = 32;
    localparam int DVS_BITS = 16;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DIV  = 2'b10
    } state_t;

endpackage

`default_nettype wire

>>> sv/mdu_divide_32_by_16.sv
// Register-mapped 32 by 16 divide unit with a bit-serial restoring divider.
`default_nettype none

// Each transaction on the input stream is one bus access to the unit (write, read, tick or no-op)
// and produces exactly one output transaction holding the addressed register after the access and
// the busy flag. Reads, ticks and ordinary writes are answered from the idle state. The write to
// MD5 that completes the sequence MD0..MD5 with a nonzero divisor starts the radix-2 restoring
// divider, which retires one quotient bit per cycle, and that access gets its output transaction
// after the last bit; a zero divisor sets the overflow flag. One access is processed at a time.
module mdu_divide_32_by_16
    import mdu_pkg::*;
#(
    parameter int CALC_TICKS = 6
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // req_type[1:0], reg_index[4:2], write_data[12:5]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // read_data[7:0], busy_res[8]
);

    localparam logic [2:0] CALC_LOAD = 3'(CALC_TICKS);
    localparam logic [4:0] LAST_BIT  = 5'(DIV_BITS - 1);
    localparam logic [2:0] LAST_SLOT = 3'(NUM_DATA_REGS);

    state_t state_reg, state_next;
    logic [7:0] data_reg [NUM_DATA_REGS];
    logic [7:0] data_next [NUM_DATA_REGS];
    logic [7:0] status_reg, status_next;
    logic [2:0] count_reg, count_next;
    logic       match_reg, match_next;
    logic [2:0] busy_reg, busy_next;
    logic [4:0] bit_reg, bit_next;
    logic [31:0] quo_reg, quo_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] dvs_reg, dvs_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg, out_data_next;
    logic       out_busy_reg, out_busy_next;

    req_t       req;
    logic [2:0] idx;
    logic [7:0] val;
    logic       accept;
    logic [2:0] slot;
    logic       slot_match;
    logic [16:0] shifted;
    logic [17:0] diff;
    logic [15:0] step_rem;
    logic [31:0] step_quo;

    assign req    = req_t'(s_tdata[1:0]);
    assign idx    = s_tdata[4:2];
    assign val    = s_tdata[12:5];
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_busy_reg, out_data_reg};

    assign shifted = {rem_reg, quo_reg[31]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign step_rem = diff[17] ? shifted[15:0] : diff[15:0];
    assign step_quo = {quo_reg[30:0], ~diff[17]};

    always_comb
    begin
        state_next     = state_reg;
        data_next      = data_reg;
        status_next    = status_reg;
        count_next     = count_reg;
        match_next     = match_reg;
        busy_next      = busy_reg;
        bit_next       = bit_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_busy_next  = out_busy_reg;
        slot           = count_reg;
        slot_match     = match_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req == REQ_WRITE)
                    begin
                        if (idx < REG_STATUS)
                        begin
                            if (busy_reg != 3'd0)
                            begin
                                status_next = status_reg | ST_ERROR;
                            end
                            else
                            begin
                                if (idx == REG_MD0)
                                begin
                                    slot       = 3'd0;
                                    slot_match = 1'b1;
                                end
                                if (slot == LAST_SLOT)
                                begin
                                    status_next = status_reg | ST_ERROR;
                                    count_next  = slot;
                                    match_next  = slot_match;
                                end
                                else
                                begin
                                    data_next[idx] = val;
                                    match_next     = slot_match && (idx == slot);
                                    count_next     = slot + 3'd1;
                                    if (count_next == LAST_SLOT && match_next)
                                    begin
                                        if ({val, data_reg[REG_MD4]} == 16'd0)
                                        begin
                                            status_next = status_reg | ST_OVERFLOW;
                                            for (int i = 0; i < NUM_DATA_REGS; i++)
                                            begin
                                                data_next[i] = 8'd0;
                                            end
                                            busy_next = CALC_LOAD;
                                        end
                                        else
                                        begin
                                            state_next = ST_DIV;
                                            bit_next   = LAST_BIT;
                                            rem_next   = 16'd0;
                                            dvs_next   = {val, data_reg[REG_MD4]};
                                            quo_next   = {data_reg[3], data_reg[2],
                                                          data_reg[1], data_reg[0]};
                                        end
                                    end
                                    else if (count_next == LAST_SLOT)
                                    begin
                                        status_next = status_reg | ST_ERROR;
                                    end
                                end
                            end
                        end
                        else if (idx == REG_STATUS)
                        begin
                            status_next = val;
                        end
                    end
                    else if (req == REQ_TICK)
                    begin
                        if (busy_reg != 3'd0)
                        begin
                            busy_next = busy_reg - 3'd1;
                        end
                    end

                    if (state_next == ST_IDLE)
                    begin
                        out_valid_next = 1'b1;
                        out_busy_next  = (busy_next != 3'd0);
                        if (idx < REG_STATUS)
                        begin
                            out_data_next = data_next[idx];
                        end
                        else if (idx == REG_STATUS)
                        begin
                            out_data_next = status_next;
                        end
                        else
                        begin
                            out_data_next = 8'd0;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = step_rem;
                quo_next = step_quo;
                bit_next = bit_reg - 5'd1;
                if (bit_reg == 5'd0)
                begin
                    state_next   = ST_IDLE;
                    data_next[0] = step_quo[7:0];
                    data_next[1] = step_quo[15:8];
                    data_next[2] = step_quo[23:16];
                    data_next[3] = step_quo[31:24];
                    data_next[4] = step_rem[7:0];
                    data_next[5] = step_rem[15:8];
                    status_next  = status_reg & ~ST_OVERFLOW;
                    busy_next    = CALC_LOAD;
                    out_valid_next = 1'b1;
                    out_data_next  = step_rem[15:8];
                    out_busy_next  = (CALC_LOAD != 3'd0);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int i = 0; i < NUM_DATA_REGS; i++)
            begin
                data_reg[i] <= 8'd0;
            end
            status_reg    <= 8'd0;
            count_reg     <= 3'd0;
            match_reg     <= 1'b0;
            busy_reg      <= 3'd0;
            bit_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            data_reg      <= data_next;
            status_reg    <= status_next;
            count_reg     <= count_next;
            match_reg     <= match_next;
            busy_reg      <= busy_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        dvs_reg      <= dvs_next;
        out_data_reg <= out_data_next;
        out_busy_reg <= out_busy_next;
    end

endmodule

`default_nettype wire
